>>> rtl/core/utf8_identifier_escaper_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 identifier escaper: assertion macros
// Shared property wrappers on clk with a synchronous rst.
// ----------------------------------------------------------------------------
`ifndef UTF8_IDENTIFIER_ESCAPER_DEFINES_SVH
`define UTF8_IDENTIFIER_ESCAPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define UIE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/uie_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 identifier escaper package
// Widths, character and error codes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uie_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAR_W     = 7;
  localparam int ERR_W      = 2;
  localparam int CODE_W     = 31;
  localparam int PEND_W     = 3;
  localparam int DIGIT_W    = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int CONV_STEPS = CODE_W;
  localparam int CONV_CNT_W = $clog2(CONV_STEPS);
  localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);

  // Error codes carried on a result
  localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID_LEAD = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED    = 2'd2;

  // ASCII characters
  localparam logic [CHAR_W-1:0] CH_NUL        = 7'd0;
  localparam logic [CHAR_W-1:0] CH_PLUS       = 7'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 7'd48;
  localparam logic [CHAR_W-1:0] CH_NINE       = 7'd57;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 7'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 7'd90;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 7'd95;
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = 7'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 7'd122;

  // Lead byte upper bounds per sequence length
  localparam logic [BYTE_W-1:0] LEAD_MAX_1 = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD_MAX_2 = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD_MAX_3 = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD_MAX_4 = 8'hF7;
  localparam logic [BYTE_W-1:0] LEAD_MAX_5 = 8'hFB;
  localparam logic [BYTE_W-1:0] LEAD_MAX_6 = 8'hFD;
  localparam logic [BYTE_W-1:0] LEAD_MASK  = 8'h7F;
  localparam int                CONT_BITS  = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_US2,
    S_END,
    S_CONV,
    S_DIGIT,
    S_CLOSE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } bcd_ctrl_t;

  typedef struct packed {
    logic               conv_done;
    logic               skip;
    logic               last_digit;
    logic [DIGIT_W-1:0] top;
  } bcd_stat_t;

  // Characters that pass through unescaped: + - 0-9 A-Z a-z
  function automatic logic plain_char(input logic [CODE_W-1:0] code);
    logic               small_code;
    logic [CHAR_W-1:0]  c;
    small_code = (code[CODE_W-1:CHAR_W] == '0);
    c          = code[CHAR_W-1:0];
    return small_code &&
           ((c == CH_PLUS) || (c == CH_MINUS) ||
            ((c >= CH_ZERO) && (c <= CH_NINE)) ||
            ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
            ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)));
  endfunction

endpackage

>>> rtl/core/utf8_identifier_escaper.sv
// ----------------------------------------------------------------------------
// UTF-8 identifier escaper
// Decodes zero-terminated byte strings (optionally as UTF-8) and emits an
// identifier-safe ASCII stream, escaping other code points as _<decimal>_.
// ----------------------------------------------------------------------------
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   input    | in_valid / in_stall       | in_byte
//   output   | out_valid / out_stall     | out_char, char_valid, last_of_run,
//            |                           | string_end, error_code
//   config   | cfg_we                    | cfg_wdata (utf_mode)
//
// A plain character, a lead byte or a continuation byte is taken in S_IDLE.
// An escaped code converts in S_CONV, one bit per cycle through the shared
// BCD unit, emits digits in S_DIGIT (leading zeros skipped), one digit shift per
// cycle while the output is free, then closes in S_CLOSE.
// Reset is synchronous and clears the decoder state and utf_mode.
// Input is stalled while a run of results is being produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_identifier_escaper_defines.svh"

module utf8_identifier_escaper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uie_pkg::BYTE_W-1:0]  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [uie_pkg::CHAR_W-1:0]  out_char,
  output logic                        char_valid,
  output logic                        last_of_run,
  output logic                        string_end,
  output logic [uie_pkg::ERR_W-1:0]   error_code
);
  import uie_pkg::*;

  state_t            state;
  state_t            state_next;
  logic              utf_mode;
  logic [PEND_W-1:0] bytes_pending;
  logic [CODE_W-1:0] partial_code;
  logic              emitted_any;
  logic [ERR_W-1:0]  err_hold;

  logic              out_free;
  logic              in_acc;

  logic              is_end;
  logic              in_seq;
  logic              seq_done;
  logic              direct;
  logic              invalid_lead;
  logic              do_emit;
  logic              is_plain;
  logic [CODE_W-1:0] cont_code;
  logic [CODE_W-1:0] code_sel;
  logic [PEND_W-1:0] lead_len;
  logic [BYTE_W-1:0] lead_bits;

  logic              ld;
  logic [CHAR_W-1:0] ld_char;
  logic              ld_valid;
  logic              ld_last;
  logic              ld_end;
  logic [ERR_W-1:0]  ld_err;

  bcd_ctrl_t         bcd_ctrl;
  bcd_stat_t         bcd_stat;

  uie_bcd u_bcd (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (bcd_ctrl),
    .load_value (code_sel),
    .stat       (bcd_stat)
  );

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Classify the incoming byte
  always_comb begin
    is_end       = (in_byte == '0);
    in_seq       = (bytes_pending != '0);
    seq_done     = (bytes_pending == PEND_W'(1));
    direct       = !utf_mode || (in_byte <= LEAD_MAX_1);
    invalid_lead = (in_byte > LEAD_MAX_6);
    cont_code    = {partial_code[CODE_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};
    code_sel     = in_seq ? cont_code : {{(CODE_W-BYTE_W){1'b0}}, in_byte};
    do_emit      = !is_end && (in_seq ? seq_done : direct);
    is_plain     = plain_char(code_sel);
    if (in_byte <= LEAD_MAX_2) begin
      lead_len = PEND_W'(2);
    end else if (in_byte <= LEAD_MAX_3) begin
      lead_len = PEND_W'(3);
    end else if (in_byte <= LEAD_MAX_4) begin
      lead_len = PEND_W'(4);
    end else if (in_byte <= LEAD_MAX_5) begin
      lead_len = PEND_W'(5);
    end else begin
      lead_len = PEND_W'(6);
    end
    lead_bits = in_byte & (LEAD_MASK >> lead_len);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (is_end && !emitted_any) begin
            state_next = S_US2;
          end else if (do_emit && !is_plain) begin
            state_next = S_CONV;
          end
        end
      end
      S_US2: begin
        if (out_free) state_next = S_END;
      end
      S_END: begin
        if (out_free) state_next = S_IDLE;
      end
      S_CONV: begin
        if (bcd_stat.conv_done) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (!bcd_stat.skip && out_free && bcd_stat.last_digit) state_next = S_CLOSE;
      end
      S_CLOSE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result loads and converter control
  always_comb begin
    ld             = 1'b0;
    ld_char        = CH_UNDERSCORE;
    ld_valid       = 1'b1;
    ld_last        = 1'b0;
    ld_end         = 1'b0;
    ld_err         = ERR_NONE;
    bcd_ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (is_end) begin
            ld = 1'b1;
            if (emitted_any) begin
              ld_char  = CH_NUL;
              ld_valid = 1'b0;
              ld_last  = 1'b1;
              ld_end   = 1'b1;
              ld_err   = in_seq ? ERR_TRUNCATED : ERR_NONE;
            end
          end else if (do_emit) begin
            ld = 1'b1;
            if (is_plain) begin
              ld_char = code_sel[CHAR_W-1:0];
              ld_last = 1'b1;
            end else begin
              bcd_ctrl.load = 1'b1;
            end
          end else if (!in_seq && invalid_lead) begin
            ld       = 1'b1;
            ld_char  = CH_NUL;
            ld_valid = 1'b0;
            ld_last  = 1'b1;
            ld_err   = ERR_INVALID_LEAD;
          end
        end
      end
      S_US2: begin
        ld = out_free;
      end
      S_END: begin
        ld       = out_free;
        ld_char  = CH_NUL;
        ld_valid = 1'b0;
        ld_last  = 1'b1;
        ld_end   = 1'b1;
        ld_err   = err_hold;
      end
      S_CONV: begin
        bcd_ctrl.step = 1'b1;
      end
      S_DIGIT: begin
        if (bcd_stat.skip) begin
          bcd_ctrl.shift = 1'b1;
        end else if (out_free) begin
          ld             = 1'b1;
          ld_char        = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_stat.top};
          bcd_ctrl.shift = 1'b1;
        end
      end
      S_CLOSE: begin
        ld      = out_free;
        ld_last = 1'b1;
      end
      default: ld = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      utf_mode      <= 1'b0;
      bytes_pending <= '0;
      partial_code  <= '0;
      emitted_any   <= 1'b0;
      err_hold      <= ERR_NONE;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) utf_mode <= cfg_wdata;
      if (in_acc) begin
        if (is_end) begin
          bytes_pending <= '0;
          partial_code  <= '0;
          emitted_any   <= 1'b0;
          err_hold      <= in_seq ? ERR_TRUNCATED : ERR_NONE;
        end else if (in_seq) begin
          bytes_pending <= bytes_pending - PEND_W'(1);
          partial_code  <= seq_done ? '0 : cont_code;
          if (seq_done) emitted_any <= 1'b1;
        end else if (direct) begin
          emitted_any <= 1'b1;
        end else if (!invalid_lead) begin
          bytes_pending <= lead_len - PEND_W'(1);
          partial_code  <= {{(CODE_W-BYTE_W){1'b0}}, lead_bits};
        end
      end
      // Hold the beat until taken, then drop it
      if (ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (ld) begin
      out_char    <= ld_char;
      char_valid  <= ld_valid;
      last_of_run <= ld_last;
      string_end  <= ld_end;
      error_code  <= ld_err;
    end
  end

  `UIE_ASSERT_SAME(a_end_beat_shape, out_valid && string_end, !char_valid && last_of_run && out_char == CH_NUL, "end beat must carry no character and close the run")
  `UIE_ASSERT_SAME(a_conv_holds_underscore, state == S_CONV && out_valid, out_char == CH_UNDERSCORE && !last_of_run, "opening underscore must be pending during conversion")
  `UIE_ASSERT_NEXT(a_end_clears_string, in_acc && is_end, !emitted_any && bytes_pending == '0, "string end must clear decoder state")
  `UIE_ASSERT_SAME(a_busy_no_pending_seq, state != S_IDLE && state != S_US2 && state != S_END, bytes_pending == '0, "escape run must not overlap a pending sequence")

endmodule

>>> rtl/core/uie_bcd.sv
// ----------------------------------------------------------------------------
// UTF-8 identifier escaper: decimal digit unit
// Shift-and-add-3 binary to BCD converter, one bit per cycle, followed by a
// digit shifter that presents digits most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uie_bcd (
  input  logic                     clk,
  input  logic                     rst,
  input  uie_pkg::bcd_ctrl_t       ctrl,
  input  logic [uie_pkg::CODE_W-1:0] load_value,
  output uie_pkg::bcd_stat_t       stat
);
  import uie_pkg::*;

  logic [CODE_W-1:0]     bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CONV_CNT_W-1:0] conv_cnt;
  logic [DIG_CNT_W-1:0]  dig_left;
  logic                  started;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Payload: binary and BCD working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= load_value;
      bcd <= '0;
    end else if (ctrl.step) begin
      bin <= {bin[CODE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[CODE_W-1]};
    end else if (ctrl.shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // Control: step and digit counters, leading-zero tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_cnt <= '0;
      dig_left <= '0;
      started  <= 1'b0;
    end else if (ctrl.load) begin
      conv_cnt <= '0;
      dig_left <= DIG_CNT_W'(BCD_DIGITS);
      started  <= 1'b0;
    end else if (ctrl.step) begin
      conv_cnt <= conv_cnt + CONV_CNT_W'(1);
    end else if (ctrl.shift) begin
      dig_left <= dig_left - DIG_CNT_W'(1);
      started  <= started | !stat.skip;
    end
  end

  always_comb begin
    stat.top        = bcd[BCD_W-1 -: DIGIT_W];
    stat.conv_done  = (conv_cnt == CONV_CNT_W'(CONV_STEPS - 1));
    stat.last_digit = (dig_left == DIG_CNT_W'(1));
    stat.skip       = (stat.top == '0) && !started && (dig_left > DIG_CNT_W'(1));
  end

endmodule
